### hw/rtl/stb_pkg.sv
// Shared types and constants for the software timer bank.
// No dependencies; used by stb_cell, stb_ctrl and software_timer_bank.
`default_nettype none

package stb_pkg;

    localparam int TIMER_SLOTS = 8;
    localparam int SLOT_W      = 3;

    // operation codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SCAN   = 3'd1;
    localparam logic [2:0] OP_CREATE = 3'd2;
    localparam logic [2:0] OP_START  = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_DELETE = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_CREATED = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_FIRED   = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // token walking the cell chain during a scan or create
    typedef struct packed {
        logic valid;
        logic create;
    } token_t;

    // values broadcast from the controller to every cell
    typedef struct packed {
        logic [31:0] tick;
        logic [31:0] ivl;
        logic        rep;
        logic        ctl_en;
        logic [2:0]  ctl_op;
    } bcast_t;

endpackage

`default_nettype wire

### hw/rtl/stb_cell.sv
// One timer slot: holds its own state, evaluates the walking token and
// passes it on. Depends on stb_pkg.
`default_nettype none

module stb_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire stb_pkg::bcast_t bc,
    input  wire logic            sel,
    input  wire stb_pkg::token_t tok_in,
    output stb_pkg::token_t      tok_out,
    output logic                 hit
);
    import stb_pkg::*;

    token_t      tok_reg;
    logic        in_use_reg, in_use_next;
    logic        running_reg, running_next;
    logic        periodic_reg, periodic_next;
    logic [31:0] ivl_reg, ivl_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] elapsed;
    logic        due;
    logic        claim;
    logic        fire;

    assign elapsed = bc.tick - last_reg;
    assign due     = in_use_reg && running_reg && (elapsed >= ivl_reg);
    assign claim   = tok_reg.valid && tok_reg.create && !in_use_reg;
    assign fire    = tok_reg.valid && !tok_reg.create && due;
    assign hit     = claim || fire;

    // a create token stops at the first free slot; a scan token runs through
    always_comb
    begin
        tok_out.valid  = tok_reg.valid && !claim;
        tok_out.create = tok_reg.create;
    end

    always_comb
    begin
        in_use_next   = in_use_reg;
        running_next  = running_reg;
        periodic_next = periodic_reg;
        ivl_next      = ivl_reg;
        last_next     = last_reg;
        if (claim)
        begin
            in_use_next   = 1'b1;
            running_next  = 1'b0;
            periodic_next = bc.rep;
            ivl_next      = bc.ivl;
            last_next     = '0;
        end
        else if (fire)
        begin
            last_next = bc.tick;
            if (!periodic_reg)
            begin
                running_next = 1'b0;
            end
        end
        else if (bc.ctl_en && sel)
        begin
            case (bc.ctl_op)
                OP_START:
                begin
                    if (in_use_reg)
                    begin
                        running_next = 1'b1;
                        last_next    = bc.tick;
                    end
                end
                OP_STOP:
                begin
                    running_next = 1'b0;
                end
                OP_DELETE:
                begin
                    in_use_next  = 1'b0;
                    running_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= '0;
            in_use_reg  <= 1'b0;
            running_reg <= 1'b0;
        end
        else
        begin
            tok_reg     <= tok_in;
            in_use_reg  <= in_use_next;
            running_reg <= running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        periodic_reg <= periodic_next;
        ivl_reg      <= ivl_next;
        last_reg     <= last_next;
    end

endmodule

`default_nettype wire

### hw/rtl/stb_ctrl.sv
// Controller: tick counter, command decode, token launch and result
// ordering for the cell chain. Depends on stb_pkg.
`default_nettype none

module stb_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [2:0]                       operation,
    input  wire logic [31:0]                      interval,
    input  wire logic                             repeat_mode,
    input  wire logic [stb_pkg::TIMER_SLOTS-1:0]  hits,
    input  wire stb_pkg::token_t                  tail,
    output logic                                  busy,
    output stb_pkg::bcast_t                       bc,
    output stb_pkg::token_t                       launch,
    output logic                                  strobe,
    output logic [1:0]                            result_kind,
    output logic [2:0]                            slot,
    output logic                                  last
);
    import stb_pkg::*;

    state_t              state_reg, state_next;
    logic [31:0]         tick_reg, tick_next;
    logic [31:0]         ivl_reg;
    logic                rep_reg;
    logic                create_reg;
    logic [SLOT_W-1:0]   step_reg, step_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    token_t              tail_reg;
    logic                strobe_reg, strobe_next;
    logic [1:0]          kind_reg, kind_next;
    logic [2:0]          slot_reg, slot_next;
    logic                last_reg, last_next;
    logic                accept;
    logic                walk;
    logic                any_hit;

    assign accept  = start && !busy;
    assign walk    = (operation == OP_SCAN) || (operation == OP_CREATE);
    assign any_hit = |hits;
    assign busy    = (state_reg != ST_IDLE);

    assign launch.valid  = accept && walk;
    assign launch.create = (operation == OP_CREATE);

    always_comb
    begin
        bc.tick   = tick_reg;
        bc.ivl    = ivl_reg;
        bc.rep    = rep_reg;
        bc.ctl_en = accept;
        bc.ctl_op = operation;
    end

    assign tick_next = (accept && operation == OP_TICK) ? tick_reg + 32'd1 : tick_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && walk)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if ((create_reg && any_hit) || tail_reg.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // results; a fired slot is held pending so the final one can carry last
    always_comb
    begin
        step_next       = '0;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        strobe_next     = 1'b0;
        kind_next       = KIND_NONE;
        slot_next       = '0;
        last_next       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pend_valid_next = 1'b0;
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (any_hit)
                begin
                    if (create_reg)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_CREATED;
                        slot_next   = 3'(step_reg);
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        if (pend_valid_reg)
                        begin
                            strobe_next = 1'b1;
                            kind_next   = KIND_FIRED;
                            slot_next   = 3'(pend_slot_reg);
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = step_reg;
                    end
                end
                else if (tail_reg.valid)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    if (create_reg)
                    begin
                        kind_next = KIND_FULL;
                    end
                    else if (pend_valid_reg)
                    begin
                        kind_next = KIND_FIRED;
                        slot_next = 3'(pend_slot_reg);
                    end
                    else
                    begin
                        kind_next = KIND_NONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            tail_reg       <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            tail_reg       <= tail;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && walk)
        begin
            ivl_reg    <= interval;
            rep_reg    <= repeat_mode;
            create_reg <= (operation == OP_CREATE);
        end
        pend_slot_reg <= pend_slot_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        last_reg      <= last_next;
    end

    assign strobe      = strobe_reg;
    assign result_kind = kind_reg;
    assign slot        = slot_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

### hw/rtl/software_timer_bank.sv
// Software timer bank: 8 timer slots, each a cell of a chain walked by a token.
// Tick, start, stop, delete: busy never rises, no result. Create: busy until
// the token stops at the first free cell, or runs off the end for bank full;
// its one result strobes in the first cycle with busy low. Scan: busy while the
// token walks every cell and the chain end; each fired slot strobes one result,
// the final one with last, or one none result with last if no slot fires. The
// receiver cannot stall. Reset: tick count zero, all slots free and disarmed.
`default_nettype none

module software_timer_bank (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  operation,
    input  wire logic [2:0]  target_slot,
    input  wire logic [31:0] interval,
    input  wire logic        repeat_mode,
    output logic             strobe,
    output logic [1:0]       result_kind,
    output logic [2:0]       slot,
    output logic             last
);
    import stb_pkg::*;

    bcast_t                  bc;
    token_t                  tok [0:TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0]  hits;
    logic [TIMER_SLOTS-1:0]  sel;

    stb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .operation   (operation),
        .interval    (interval),
        .repeat_mode (repeat_mode),
        .hits        (hits),
        .tail        (tok[TIMER_SLOTS]),
        .busy        (busy),
        .bc          (bc),
        .launch      (tok[0]),
        .strobe      (strobe),
        .result_kind (result_kind),
        .slot        (slot),
        .last        (last)
    );

    for (genvar i = 0; i < TIMER_SLOTS; i++)
    begin : g_cell
        assign sel[i] = (target_slot == SLOT_W'(i));

        stb_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bc      (bc),
            .sel     (sel[i]),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .hit     (hits[i])
        );
    end

endmodule

`default_nettype wire
